>>> rtl/core/interval_aliasing_resource_pool_defines.svh
// Assertion macros shared by the resource pool RTL
`ifndef INTERVAL_ALIASING_RESOURCE_POOL_DEFINES_SVH
`define INTERVAL_ALIASING_RESOURCE_POOL_DEFINES_SVH

// same-cycle implication, held off during reset
`define IARP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define IARP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/iarp_pkg.sv
// Shared types and codes of the resource pool
package iarp_pkg;

	localparam int KEY_W = 48;
	localparam int IV_W  = 32;

	localparam logic [1:0] FN_ACQ_TEX = 2'd0;
	localparam logic [1:0] FN_ACQ_BUF = 2'd1;
	localparam logic [1:0] FN_BEGIN   = 2'd2;

	localparam logic [1:0] ST_REUSED = 2'd0;
	localparam logic [1:0] ST_NEW    = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BEGUN  = 2'd3;

	typedef enum logic [1:0] {
		CMP_KEY,
		CMP_IV,
		CMP_AGE
	} cmp_op_t;

	typedef struct packed {
		cmp_op_t           op;
		logic [KEY_W-1:0]  req_key;
		logic [KEY_W-1:0]  ent_key;
		logic [15:0]       span_first;
		logic [15:0]       span_last;
		logic [15:0]       iv_first;
		logic [15:0]       iv_last;
		logic [31:0]       frame;
		logic [31:0]       last_frame;
		logic [7:0]        age;
	} cmp_req_t;

endpackage

>>> rtl/core/iarp_ram.sv
// Generic single-write, single-read RAM with registered read
module iarp_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                 wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                 rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/iarp_cmp.sv
// Shared compare unit: key match, span overlap, age survival
module iarp_cmp (
	input  iarp_pkg::cmp_req_t req,
	output logic               hit
);

	logic [32:0] limit;

	assign limit = {1'b0, req.last_frame} + {25'd0, req.age};

	always_comb begin
		unique case (req.op)
			iarp_pkg::CMP_KEY: hit = (req.req_key == req.ent_key);
			iarp_pkg::CMP_IV:  hit = (req.span_first <= req.iv_last) &&
			                         (req.iv_first <= req.span_last);
			iarp_pkg::CMP_AGE: hit = ({1'b0, req.frame} <= limit);
			default:           hit = 1'b0;
		endcase
	end

endmodule

>>> rtl/core/interval_aliasing_resource_pool.sv
// Top level: first-fit interval allocator over texture and buffer pools
//
//  channel | signals                                     | direction
//  in      | in_valid/in_ready, func .. frame_number      | into block
//  out     | out_valid/out_ready, slot, status            | out of block
//  cfg     | cfg_we, cfg_wdata (eviction_age)             | into block
//
// One word at a time. An acquire reads and checks each entry visited, then each
// interval checked (one shared compare unit, registered RAM reads). Begin frame
// reads and checks each live entry of each pool; an ignored selector goes
// straight to the result.
// No clearing pass after reset; entries above the pool counts are never read.
// A finished result waits in the output register; a new word is taken
// meanwhile, but its result waits until the register is free.
module interval_aliasing_resource_pool #(
	parameter int MAX_TEXTURES  = 16,
	parameter int MAX_BUFFERS   = 16,
	parameter int MAX_INTERVALS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [15:0] width,
	input  logic [15:0] height,
	input  logic [7:0]  pixel_format,
	input  logic [3:0]  mip_levels,
	input  logic [31:0] buffer_size,
	input  logic [15:0] buffer_usage,
	input  logic [15:0] pass_first,
	input  logic [15:0] pass_last,
	input  logic [31:0] frame_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  slot,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	`include "interval_aliasing_resource_pool_defines.svh"

	localparam int MAXP = (MAX_TEXTURES > MAX_BUFFERS) ? MAX_TEXTURES : MAX_BUFFERS;
	localparam int IW   = $clog2(MAXP + 1);
	localparam int CW   = $clog2(MAX_INTERVALS + 1);
	localparam int ENT  = MAX_TEXTURES + MAX_BUFFERS;
	localparam int EA_W = $clog2(ENT);
	localparam int IVD  = ENT * MAX_INTERVALS;
	localparam int IA_W = $clog2(IVD);
	localparam int KW   = iarp_pkg::KEY_W;

	typedef enum logic [3:0] {
		S_IDLE, S_KEY_RD, S_KEY_CHK, S_IV_RD, S_IV_CHK,
		S_COMMIT, S_APPEND, S_EV_RD, S_EV_CHK, S_DONE
	} state_t;

	state_t          state_q;
	logic [KW-1:0]   key_q;
	logic [15:0]     first_q, last_q;
	logic [31:0]     frame_q;
	logic            pool_q;
	logic [IW-1:0]   i_q, w_q, tex_cnt_q, buf_cnt_q;
	logic [CW-1:0]   j_q, n_q;
	logic [7:0]      age_q;
	logic [3:0]      res_slot_q, slot_q;
	logic [1:0]      res_status_q, status_q;
	logic            ovalid_q;

	logic [IW-1:0]   cur_cnt, cur_cap;
	logic [EA_W-1:0] base, ent_rd, ent_wr;
	logic [IA_W-1:0] iv_addr;
	logic [KW-1:0]   key_rd, key_wd;
	logic [31:0]     frm_rd, frm_wd;
	logic [CW-1:0]   cnt_rd, cnt_wd;
	logic [31:0]     iv_rd;
	logic            ent_we, iv_we, hit;
	iarp_pkg::cmp_req_t cmp_req;

	assign cur_cnt = pool_q ? buf_cnt_q : tex_cnt_q;
	assign cur_cap = pool_q ? IW'(MAX_BUFFERS) : IW'(MAX_TEXTURES);
	assign base    = pool_q ? EA_W'(MAX_TEXTURES) : '0;
	assign ent_rd  = base + EA_W'(i_q);
	assign ent_wr  = base + EA_W'((state_q == S_EV_CHK) ? w_q : i_q);
	assign iv_addr = IA_W'(ent_rd) * IA_W'(MAX_INTERVALS) +
	                 IA_W'((state_q == S_IV_RD) ? j_q : n_q);

	always_comb begin
		ent_we = 1'b0;
		iv_we  = 1'b0;
		key_wd = key_q;
		frm_wd = frame_q;
		cnt_wd = n_q + CW'(1);
		unique case (state_q)
			S_COMMIT: begin
				ent_we = 1'b1;
				iv_we  = 1'b1;
				key_wd = key_rd;
			end
			S_APPEND: begin
				ent_we = (cur_cnt < cur_cap);
				iv_we  = (cur_cnt < cur_cap);
			end
			S_EV_CHK: begin
				ent_we = hit;
				key_wd = key_rd;
				frm_wd = frm_rd;
				cnt_wd = '0;
			end
			default: ;
		endcase
	end

	// key of the entry re-read is still on the read port while committing
	iarp_ram #(.W(KW), .D(ENT)) u_key_ram (
		.clk(clk), .we(ent_we), .waddr(ent_wr), .wdata(key_wd),
		.raddr(ent_rd), .rdata(key_rd)
	);
	iarp_ram #(.W(32), .D(ENT)) u_frm_ram (
		.clk(clk), .we(ent_we), .waddr(ent_wr), .wdata(frm_wd),
		.raddr(ent_rd), .rdata(frm_rd)
	);
	iarp_ram #(.W(CW), .D(ENT)) u_cnt_ram (
		.clk(clk), .we(ent_we), .waddr(ent_wr), .wdata(cnt_wd),
		.raddr(ent_rd), .rdata(cnt_rd)
	);
	iarp_ram #(.W(iarp_pkg::IV_W), .D(IVD)) u_iv_ram (
		.clk(clk), .we(iv_we), .waddr(iv_addr), .wdata({first_q, last_q}),
		.raddr(iv_addr), .rdata(iv_rd)
	);

	always_comb begin
		cmp_req.op = iarp_pkg::CMP_AGE;
		if (state_q == S_KEY_CHK) begin
			cmp_req.op = iarp_pkg::CMP_KEY;
		end else if (state_q == S_IV_CHK) begin
			cmp_req.op = iarp_pkg::CMP_IV;
		end
		cmp_req.req_key    = key_q;
		cmp_req.ent_key    = key_rd;
		cmp_req.span_first = first_q;
		cmp_req.span_last  = last_q;
		cmp_req.iv_first   = iv_rd[31:16];
		cmp_req.iv_last    = iv_rd[15:0];
		cmp_req.frame      = frame_q;
		cmp_req.last_frame = frm_rd;
		cmp_req.age        = age_q;
	end

	iarp_cmp u_cmp (.req(cmp_req), .hit(hit));

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;
	assign slot      = slot_q;
	assign status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tex_cnt_q <= '0;
			buf_cnt_q <= '0;
			age_q     <= 8'd3;
			ovalid_q  <= 1'b0;
			pool_q    <= 1'b0;
			i_q       <= '0;
			w_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
		end else begin
			if (cfg_we) begin
				age_q <= cfg_wdata;
			end
			// a word leaving while the next is loaded is handled in S_DONE
			if (ovalid_q && out_ready && state_q != S_DONE) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						first_q <= pass_first;
						last_q  <= pass_last;
						frame_q <= frame_number;
						i_q     <= '0;
						w_q     <= '0;
						pool_q  <= (func == iarp_pkg::FN_ACQ_BUF);
						if (func == iarp_pkg::FN_ACQ_BUF) begin
							key_q <= {buffer_size, buffer_usage};
						end else begin
							key_q <= {4'd0, width, height, pixel_format, mip_levels};
						end
						unique case (func) inside
							iarp_pkg::FN_ACQ_TEX, iarp_pkg::FN_ACQ_BUF: state_q <= S_KEY_RD;
							iarp_pkg::FN_BEGIN: state_q <= S_EV_RD;
							default: begin
								res_slot_q   <= '0;
								res_status_q <= iarp_pkg::ST_FULL;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_KEY_RD: begin
					if (i_q >= cur_cnt) begin
						n_q     <= '0;
						state_q <= S_APPEND;
					end else begin
						state_q <= S_KEY_CHK;
					end
				end
				S_KEY_CHK: begin
					if (!hit || cnt_rd >= CW'(MAX_INTERVALS)) begin
						i_q     <= i_q + IW'(1);
						state_q <= S_KEY_RD;
					end else begin
						n_q     <= cnt_rd;
						j_q     <= '0;
						state_q <= S_IV_RD;
					end
				end
				S_IV_RD: begin
					state_q <= (j_q == n_q) ? S_COMMIT : S_IV_CHK;
				end
				S_IV_CHK: begin
					if (hit) begin
						i_q     <= i_q + IW'(1);
						state_q <= S_KEY_RD;
					end else begin
						j_q     <= j_q + CW'(1);
						state_q <= S_IV_RD;
					end
				end
				S_COMMIT: begin
					res_slot_q   <= 4'(i_q);
					res_status_q <= iarp_pkg::ST_REUSED;
					state_q      <= S_DONE;
				end
				S_APPEND: begin
					if (cur_cnt >= cur_cap) begin
						res_slot_q   <= '0;
						res_status_q <= iarp_pkg::ST_FULL;
					end else begin
						res_slot_q   <= 4'(i_q);
						res_status_q <= iarp_pkg::ST_NEW;
						if (pool_q) begin
							buf_cnt_q <= buf_cnt_q + IW'(1);
						end else begin
							tex_cnt_q <= tex_cnt_q + IW'(1);
						end
					end
					state_q <= S_DONE;
				end
				S_EV_RD: begin
					if (i_q >= cur_cnt) begin
						if (pool_q) begin
							buf_cnt_q    <= w_q;
							res_slot_q   <= '0;
							res_status_q <= iarp_pkg::ST_BEGUN;
							state_q      <= S_DONE;
						end else begin
							tex_cnt_q <= w_q;
							pool_q    <= 1'b1;
							i_q       <= '0;
							w_q       <= '0;
						end
					end else begin
						state_q <= S_EV_CHK;
					end
				end
				S_EV_CHK: begin
					// survivors slide down to the write index, order kept
					if (hit) begin
						w_q <= w_q + IW'(1);
					end
					i_q     <= i_q + IW'(1);
					state_q <= S_EV_RD;
				end
				S_DONE: begin
					if (!ovalid_q || out_ready) begin
						ovalid_q <= 1'b1;
						slot_q   <= res_slot_q;
						status_q <= res_status_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`IARP_ASSERT_NOW(a_tex_cnt_cap, 1'b1, tex_cnt_q <= IW'(MAX_TEXTURES), "texture count over cap")
	`IARP_ASSERT_NOW(a_buf_cnt_cap, 1'b1, buf_cnt_q <= IW'(MAX_BUFFERS), "buffer count over cap")
	`IARP_ASSERT_NOW(a_begun_slot, out_valid && status == iarp_pkg::ST_BEGUN, slot == 4'd0, "begin frame slot not zero")
	`IARP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "word taken while busy")

endmodule
